>>> design/lge_pkg.sv
// ----------------------------------------------------------------------------
// lge_pkg: shared types and constants of the life generation engine
// Board geometry, command codes, register indexes and the neighbourhood
// bundle passed between the sequencer and the rule unit.
// ----------------------------------------------------------------------------
package lge_pkg;

    // Board geometry, fixed by the payload field widths
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int SIZE_W      = COL_W + 1;
    localparam int MIN_SIZE    = 3;
    localparam int GEN_W       = 16;

    // Board storage: one memory row holds one board row, two buffers stacked
    localparam int RAM_DEPTH   = 2 * MAX_ROWS;
    localparam int RAM_AW      = ROW_W + 1;

    // Configuration port
    localparam int CFG_IDX_W   = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_ROWS    = 1'b1;
    localparam logic [SIZE_W-1:0]    COLUMNS_RESET     = SIZE_W'(24);
    localparam logic [SIZE_W-1:0]    ROWS_RESET        = SIZE_W'(14);

    typedef logic [MAX_COLUMNS-1:0] row_t;

    typedef enum logic [2:0] {
        CMD_WRITE   = 3'd0,
        CMD_TOGGLE  = 3'd1,
        CMD_CLEAR   = 3'd2,
        CMD_ADVANCE = 3'd3,
        CMD_READ    = 3'd4
    } command_t;

    // Eight wrapped neighbours plus the cell itself
    typedef struct packed {
        logic [7:0] neighbours;
        logic       centre;
    } nbhd_t;

endpackage

>>> design/lge_ram.sv
// ----------------------------------------------------------------------------
// lge_ram: generic single-write, single-read memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/lge_rule.sv
// ----------------------------------------------------------------------------
// lge_rule: neighbour count and survival rule
// Counts live neighbours of one cell and gives its state in the next
// generation: keep on two, live on three, dead otherwise.
// ----------------------------------------------------------------------------
module lge_rule (
    input  lge_pkg::nbhd_t nbhd,
    output logic           cell_next
);
    import lge_pkg::*;

    logic [3:0] count;

    // population count over the eight neighbours
    always_comb
    begin
        count = '0;
        for (int i = 0; i < 8; i++)
        begin
            count = count + 4'(nbhd.neighbours[i]);
        end
    end

    // rule
    always_comb
    begin
        case (count)
            4'd2:    cell_next = nbhd.centre;
            4'd3:    cell_next = 1'b1;
            default: cell_next = 1'b0;
        endcase
    end

endmodule

>>> design/life_generation_engine_unit.sv
// ----------------------------------------------------------------------------
// life_generation_engine_unit: toroidal Game of Life engine
// Double-buffered one-bit board held a row per memory word; a sequencer
// runs cell commands, board clears and generation advances; an advance goes
// through one shared neighbour/rule unit, one cell per cycle within a row.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake                | Beat contents
//  --------+-----+--------------------------+----------------------------------
//  in      | in  | in_valid / in_stall      | command, column, row, cell_in
//  out     | out | out_valid / out_stall    | cell_out, generation_count,
//          |     |                          | coord_error
//  config  | in  | config_write             | config_index, config_data
//
//  The advance is bound by the single board memory read port and the rule unit.
//  After reset a pass clears the first buffer with in_stall high.
//  A result waits in the output register while out_stall is high; the next
//  beat is taken meanwhile and its result waits until the register frees.
// ----------------------------------------------------------------------------
module life_generation_engine_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          config_write,
    input  logic [lge_pkg::CFG_IDX_W-1:0] config_index,
    input  logic [lge_pkg::SIZE_W-1:0]    config_data,
    // command channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    command,
    input  logic [lge_pkg::COL_W-1:0]     column,
    input  logic [lge_pkg::ROW_W-1:0]     row,
    input  logic                          cell_in,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          cell_out,
    output logic [lge_pkg::GEN_W-1:0]     generation_count,
    output logic                          coord_error
);
    import lge_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CELL_RD,
        S_CELL_MOD,
        S_ADV_UP,
        S_ADV_MID,
        S_ADV_DN,
        S_ADV_DST,
        S_ADV_LOAD,
        S_ADV_CELL,
        S_ADV_WR,
        S_DONE
    } state_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                      input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_W'(MIN_SIZE))
            r = SIZE_W'(MIN_SIZE);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    state_t             state_reg;
    logic [SIZE_W-1:0]  cols_cfg_reg, rows_cfg_reg;
    logic [SIZE_W-1:0]  cols_reg, rows_reg;
    logic               sel_reg;
    logic [GEN_W-1:0]   gen_reg;
    command_t           cmd_reg;
    logic [COL_W-1:0]   col_reg;
    logic [ROW_W-1:0]   row_reg;
    logic               cin_reg;
    logic [COL_W-1:0]   x_reg;
    logic [ROW_W-1:0]   y_reg;
    row_t               up_reg, mid_reg, dn_reg, dst_reg;
    logic               item_reg;
    logic               res_cell_reg, res_err_reg;
    logic               out_valid_reg, out_cell_reg, out_err_reg;
    logic [GEN_W-1:0]   out_gen_reg;

    logic [SIZE_W-1:0]  cols_in, rows_in;
    logic               coord_bad;
    logic [COL_W-1:0]   xl, xr;
    logic [ROW_W-1:0]   yu, yd;
    logic               x_last, y_last;
    logic               old_bit, new_bit;
    row_t               row_mod;
    nbhd_t              nbhd;
    logic               rule_out;
    logic               out_free;

    logic               ram_we, ram_re;
    logic [RAM_AW-1:0]  ram_waddr, ram_raddr;
    row_t               ram_wdata, ram_rdata;

    // board memory: both buffers, buffer select on the top address bit
    lge_ram #(
        .WIDTH (MAX_COLUMNS),
        .DEPTH (RAM_DEPTH)
    ) u_board (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // shared neighbour count and rule
    lge_rule u_rule (
        .nbhd      (nbhd),
        .cell_next (rule_out)
    );

    // board size in use and coordinate check at accept
    assign cols_in   = clamp_size(cols_cfg_reg, SIZE_W'(MAX_COLUMNS));
    assign rows_in   = clamp_size(rows_cfg_reg, SIZE_W'(MAX_ROWS));
    assign coord_bad = ({1'b0, column} >= cols_in) || ({1'b0, row} >= rows_in);

    // toroidal neighbour indexes
    assign x_last = (({1'b0, x_reg} + SIZE_W'(1)) == cols_reg);
    assign y_last = (({1'b0, y_reg} + SIZE_W'(1)) == rows_reg);
    assign xl = (x_reg == '0) ? COL_W'(cols_reg - SIZE_W'(1)) : x_reg - COL_W'(1);
    assign xr = x_last ? '0 : x_reg + COL_W'(1);
    assign yu = (y_reg == '0) ? ROW_W'(rows_reg - SIZE_W'(1)) : y_reg - ROW_W'(1);
    assign yd = y_last ? '0 : y_reg + ROW_W'(1);

    assign nbhd.neighbours = {up_reg[xl],  up_reg[x_reg], up_reg[xr],
                              mid_reg[xl], mid_reg[xr],
                              dn_reg[xl],  dn_reg[x_reg], dn_reg[xr]};
    assign nbhd.centre     = mid_reg[x_reg];

    // single-cell read-modify-write
    always_comb
    begin
        old_bit = ram_rdata[col_reg];
        case (cmd_reg)
            CMD_WRITE:  new_bit = cin_reg;
            CMD_TOGGLE: new_bit = ~old_bit;
            default:    new_bit = old_bit;
        endcase
        row_mod          = ram_rdata;
        row_mod[col_reg] = new_bit;
    end

    // memory port control
    always_comb
    begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        ram_raddr = {sel_reg, y_reg};
        ram_waddr = {sel_reg, y_reg};
        ram_wdata = row_mod;
        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            S_CELL_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = {sel_reg, row_reg};
            end
            S_CELL_MOD:
            begin
                ram_we    = (cmd_reg != CMD_READ);
                ram_waddr = {sel_reg, row_reg};
            end
            S_ADV_UP:
            begin
                ram_re    = 1'b1;
                ram_raddr = {sel_reg, yu};
            end
            S_ADV_MID:
            begin
                ram_re    = 1'b1;
            end
            S_ADV_DN:
            begin
                ram_re    = 1'b1;
                ram_raddr = {sel_reg, yd};
            end
            S_ADV_DST:
            begin
                ram_re    = 1'b1;
                ram_raddr = {~sel_reg, y_reg};
            end
            S_ADV_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {~sel_reg, y_reg};
                ram_wdata = dst_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign out_free = !out_valid_reg || !out_stall;

    // sequencer, board state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            cols_cfg_reg  <= COLUMNS_RESET;
            rows_cfg_reg  <= ROWS_RESET;
            sel_reg       <= 1'b0;
            gen_reg       <= '0;
            y_reg         <= '0;
            x_reg         <= '0;
            item_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // configuration writes
            if (config_write)
            begin
                case (config_index)
                    REG_BOARD_COLUMNS: cols_cfg_reg <= config_data;
                    REG_BOARD_ROWS:    rows_cfg_reg <= config_data;
                    default:
                    begin
                    end
                endcase
            end

            // output beat taken; a waiting result reloads the register instead
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        cmd_reg      <= command_t'(command);
                        col_reg      <= column;
                        row_reg      <= row;
                        cin_reg      <= cell_in;
                        cols_reg     <= cols_in;
                        rows_reg     <= rows_in;
                        y_reg        <= '0;
                        item_reg     <= 1'b1;
                        res_cell_reg <= 1'b0;
                        res_err_reg  <= 1'b0;
                        case (command_t'(command))
                            CMD_WRITE, CMD_TOGGLE, CMD_READ:
                            begin
                                if (coord_bad)
                                begin
                                    res_err_reg <= 1'b1;
                                    state_reg   <= S_DONE;
                                end
                                else
                                begin
                                    state_reg   <= S_CELL_RD;
                                end
                            end
                            CMD_CLEAR:   state_reg <= S_CLEAR;
                            CMD_ADVANCE: state_reg <= S_ADV_UP;
                            default:     state_reg <= S_DONE;
                        endcase
                    end
                end

                // sweep the whole current buffer, a row per cycle
                S_CLEAR:
                begin
                    y_reg <= y_reg + ROW_W'(1);
                    if (y_reg == ROW_W'(MAX_ROWS - 1))
                    begin
                        gen_reg   <= '0;
                        state_reg <= item_reg ? S_DONE : S_IDLE;
                    end
                end

                S_CELL_RD:
                begin
                    state_reg <= S_CELL_MOD;
                end

                S_CELL_MOD:
                begin
                    res_cell_reg <= new_bit;
                    state_reg    <= S_DONE;
                end

                // fetch the three source rows and the destination row
                S_ADV_UP:
                begin
                    state_reg <= S_ADV_MID;
                end

                S_ADV_MID:
                begin
                    up_reg    <= ram_rdata;
                    state_reg <= S_ADV_DN;
                end

                S_ADV_DN:
                begin
                    mid_reg   <= ram_rdata;
                    state_reg <= S_ADV_DST;
                end

                S_ADV_DST:
                begin
                    dn_reg    <= ram_rdata;
                    state_reg <= S_ADV_LOAD;
                end

                S_ADV_LOAD:
                begin
                    dst_reg   <= ram_rdata;
                    x_reg     <= '0;
                    state_reg <= S_ADV_CELL;
                end

                // one cell per cycle through the rule unit
                S_ADV_CELL:
                begin
                    dst_reg[x_reg] <= rule_out;
                    x_reg          <= x_reg + COL_W'(1);
                    if (x_last)
                    begin
                        state_reg <= S_ADV_WR;
                    end
                end

                S_ADV_WR:
                begin
                    y_reg <= y_reg + ROW_W'(1);
                    if (y_last)
                    begin
                        sel_reg   <= ~sel_reg;
                        gen_reg   <= gen_reg + GEN_W'(1);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_ADV_UP;
                    end
                end

                // hand the result to the output register once it is free
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_cell_reg  <= res_cell_reg;
                        out_err_reg   <= res_err_reg;
                        out_gen_reg   <= gen_reg;
                        item_reg      <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_stall         = (state_reg != S_IDLE);
    assign out_valid        = out_valid_reg;
    assign cell_out         = out_cell_reg;
    assign generation_count = out_gen_reg;
    assign coord_error      = out_err_reg;

endmodule
